>>> hdl/ilq_pkg.sv
// Shared types and codes for the indexed linked queue with free list.
package ilq_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int REQ_TYPE_W  = 2;
    localparam int ENTRY_ID_W  = 8;
    localparam int HANDLE_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;

    // Request kinds.
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Request transaction payload.
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [ENTRY_ID_W-1:0] entry_id;
        logic                  from_head;
        logic [HANDLE_W-1:0]   payload_in;
    } req_t;

    // Response transaction payload.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ENTRY_ID_W-1:0] assigned_id;
        logic [HANDLE_W-1:0]   payload_out;
        logic [ENTRY_ID_W-1:0] next_id;
        logic                  next_valid;
        logic [COUNT_W-1:0]    used_count;
    } rsp_t;

endpackage

>>> hdl/ilq_if.sv
// Valid/ready channel interface carrying one transaction payload.
interface ilq_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

>>> hdl/ilq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ilq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/indexed_linked_queue_with_free_list.sv
// Top level: entry pool with a LIFO free list and an insertion-ordered used list.
//
//  Channel | Modport | Payload type   | Direction
//  --------+---------+----------------+-----------------------------
//  req     | sink    | ilq_pkg::req_t | insert, remove or read
//  rsp     | source  | ilq_pkg::rsp_t | one response per request
//
// A request is captured in an input register, the list update and the response
// are computed from that register, and the response lands in an output register
// that drives rsp.valid. One request per cycle is sustained while rsp.ready stays
// high. Links, used bits and list pointers live in flip-flops that reset loads
// directly; handles sit in a RAM whose registered read supplies payload_out.
// A stalled rsp holds the output register and, through it, the input register.
module indexed_linked_queue_with_free_list #(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    ilq_if.sink   req,
    ilq_if.source rsp
);

    localparam int ID_W    = $clog2(DEPTH);
    localparam int LINK_W  = $clog2(DEPTH + 1);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (HANDLE_WIDTH < ilq_pkg::HANDLE_W) ? HANDLE_WIDTH
                                                                : ilq_pkg::HANDLE_W;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(DEPTH);
    localparam logic [ilq_pkg::ENTRY_ID_W:0] ID_LIMIT = (ilq_pkg::ENTRY_ID_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Input stage.
    logic          s1_valid_reg;
    ilq_pkg::req_t s1_req_reg;
    logic          advance;

    // List state.
    logic [LINK_W-1:0] next_link_reg  [DEPTH];
    logic [LINK_W-1:0] next_link_next [DEPTH];
    logic [LINK_W-1:0] prev_link_reg  [DEPTH];
    logic [LINK_W-1:0] prev_link_next [DEPTH];
    logic [DEPTH-1:0]  used_reg;
    logic [DEPTH-1:0]  used_next;
    logic [LINK_W-1:0] free_head_reg;
    logic [LINK_W-1:0] free_head_next;
    logic [LINK_W-1:0] used_head_reg;
    logic [LINK_W-1:0] used_head_next;
    logic [LINK_W-1:0] used_tail_reg;
    logic [LINK_W-1:0] used_tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // Decode of the current request.
    logic              free_nil;
    logic [ID_W-1:0]   free_idx;
    logic [ID_W-1:0]   id_idx;
    logic              id_live;
    logic [LINK_W-1:0] rm_next;
    logic [LINK_W-1:0] rm_prev;
    logic [ID_W-1:0]   rd_idx;
    logic [LINK_W-1:0] rd_link;
    logic              rd_ok;
    logic              ins_ok;

    // Response fields before the output register.
    logic [ilq_pkg::STATUS_W-1:0]   status_next;
    logic [ilq_pkg::ENTRY_ID_W-1:0] assigned_next;
    logic [ilq_pkg::ENTRY_ID_W-1:0] next_id_next;
    logic                           next_valid_next;

    // Output stage.
    logic                           out_valid_reg;
    logic [ilq_pkg::STATUS_W-1:0]   status_reg;
    logic [ilq_pkg::ENTRY_ID_W-1:0] assigned_reg;
    logic [ilq_pkg::ENTRY_ID_W-1:0] next_id_reg;
    logic                           next_valid_reg;
    logic [ilq_pkg::COUNT_W-1:0]    count_out_reg;
    logic                           rd_ok_reg;
    logic [STORE_W-1:0]             ram_rdata;

    // Handshake: the input register moves whenever the output register can take a result.
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign rsp.valid = out_valid_reg;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_req_reg <= req.payload;
        end
    end

    // Common decode of free head and requested id.
    assign free_nil = (free_head_reg == NIL);
    assign free_idx = free_head_reg[ID_W-1:0];
    assign id_idx   = s1_req_reg.entry_id[ID_W-1:0];
    assign id_live  = ({1'b0, s1_req_reg.entry_id} < ID_LIMIT) && used_reg[id_idx];
    assign rm_next  = next_link_reg[id_idx];
    assign rm_prev  = prev_link_reg[id_idx];
    assign rd_idx   = s1_req_reg.from_head ? used_head_reg[ID_W-1:0] : id_idx;
    assign rd_link  = next_link_reg[rd_idx];

    // List update and response for the request in the input register.
    always_comb
    begin
        next_link_next  = next_link_reg;
        prev_link_next  = prev_link_reg;
        used_next       = used_reg;
        free_head_next  = free_head_reg;
        used_head_next  = used_head_reg;
        used_tail_next  = used_tail_reg;
        count_next      = count_reg;
        status_next     = ilq_pkg::ST_BAD_ID;
        assigned_next   = '0;
        next_id_next    = '0;
        next_valid_next = 1'b0;
        rd_ok           = 1'b0;
        ins_ok          = 1'b0;

        case (s1_req_reg.req_type)
            ilq_pkg::REQ_INSERT:
            begin
                if (free_nil)
                begin
                    status_next = ilq_pkg::ST_FULL;
                end
                else
                begin
                    ins_ok                   = 1'b1;
                    free_head_next           = next_link_reg[free_idx];
                    next_link_next[free_idx] = NIL;
                    prev_link_next[free_idx] = used_tail_reg;
                    used_next[free_idx]      = 1'b1;
                    if (used_tail_reg != NIL)
                    begin
                        next_link_next[used_tail_reg[ID_W-1:0]] = free_head_reg;
                    end
                    else
                    begin
                        used_head_next = free_head_reg;
                    end
                    used_tail_next = free_head_reg;
                    count_next     = count_reg + 1'b1;
                    status_next    = ilq_pkg::ST_OK;
                    assigned_next  = ilq_pkg::ENTRY_ID_W'(free_idx);
                end
            end
            ilq_pkg::REQ_REMOVE:
            begin
                if (id_live)
                begin
                    // Unlink from neighbors, then push onto the free list.
                    if (rm_next != NIL)
                    begin
                        prev_link_next[rm_next[ID_W-1:0]] = rm_prev;
                    end
                    else
                    begin
                        used_tail_next = rm_prev;
                    end
                    if (rm_prev != NIL)
                    begin
                        next_link_next[rm_prev[ID_W-1:0]] = rm_next;
                    end
                    else
                    begin
                        used_head_next = rm_next;
                    end
                    next_link_next[id_idx] = free_head_reg;
                    prev_link_next[id_idx] = NIL;
                    used_next[id_idx]      = 1'b0;
                    free_head_next         = LINK_W'(id_idx);
                    count_next             = count_reg - 1'b1;
                    status_next            = ilq_pkg::ST_OK;
                end
            end
            ilq_pkg::REQ_READ:
            begin
                if (s1_req_reg.from_head && used_head_reg == NIL)
                begin
                    status_next = ilq_pkg::ST_EMPTY;
                end
                else if (s1_req_reg.from_head || id_live)
                begin
                    rd_ok       = 1'b1;
                    status_next = ilq_pkg::ST_OK;
                    if (rd_link != NIL)
                    begin
                        next_id_next    = ilq_pkg::ENTRY_ID_W'(rd_link[ID_W-1:0]);
                        next_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ilq_pkg::ST_BAD_ID;
            end
        endcase
    end

    // List state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                next_link_reg[i] <= LINK_W'(i + 1);
                prev_link_reg[i] <= NIL;
            end
            used_reg      <= '0;
            free_head_reg <= '0;
            used_head_reg <= NIL;
            used_tail_reg <= NIL;
            count_reg     <= '0;
        end
        else if (advance)
        begin
            next_link_reg <= next_link_next;
            prev_link_reg <= prev_link_next;
            used_reg      <= used_next;
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            used_tail_reg <= used_tail_next;
            count_reg     <= count_next;
        end
    end

    // Handle storage; its read data is loaded together with the output register.
    ilq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (advance && ins_ok),
        .waddr (free_idx),
        .wdata (s1_req_reg.payload_in[STORE_W-1:0]),
        .re    (advance),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg     <= status_next;
            assigned_reg   <= assigned_next;
            next_id_reg    <= next_id_next;
            next_valid_reg <= next_valid_next;
            count_out_reg  <= ilq_pkg::COUNT_W'(count_next);
            rd_ok_reg      <= rd_ok;
        end
    end

    // Response transaction assembly.
    always_comb
    begin
        rsp.payload.status      = status_reg;
        rsp.payload.assigned_id = assigned_reg;
        rsp.payload.payload_out = rd_ok_reg ? ilq_pkg::HANDLE_W'(ram_rdata) : '0;
        rsp.payload.next_id     = next_id_reg;
        rsp.payload.next_valid  = next_valid_reg;
        rsp.payload.used_count  = count_out_reg;
    end

`ifndef SYNTHESIS
    // An empty free list means every entry is in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_nil |-> (count_reg == FULL_COUNT))
    else $error("free list empty while the pool is not full");

    // The used list is empty exactly when the count is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (used_head_reg == NIL) == (count_reg == '0))
    else $error("used head disagrees with the live count");

    // Head and tail are null together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (used_head_reg == NIL) == (used_tail_reg == NIL))
    else $error("used head and tail disagree on an empty list");

    // A successful insert marks the taken entry as used.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ins_ok) |=> used_reg[$past(free_idx)])
    else $error("inserted entry not marked used");
`endif

endmodule

>>> tb/indexed_linked_queue_with_free_list_test.sv
// Self-checking testbench for the indexed linked queue with free list.
module indexed_linked_queue_with_free_list_test;

    localparam int DEPTH        = 16;
    localparam int HANDLE_WIDTH = 32;
    localparam int ID_W         = $clog2(DEPTH);
    localparam int LINK_W       = $clog2(DEPTH + 1);
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(DEPTH);
    // Request code that the block does not define; it must be rejected as a bad id.
    localparam logic [ilq_pkg::REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 100;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        ilq_pkg::rsp_t result;
        int unsigned   accept_cycle;
    } expected_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    ilq_if #(.payload_t(ilq_pkg::req_t)) req_bus ();
    ilq_if #(.payload_t(ilq_pkg::rsp_t)) rsp_bus ();

    indexed_linked_queue_with_free_list #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow of the pool: handles, links, used bits and list pointers.
    logic [ilq_pkg::HANDLE_W-1:0] slot_handle [DEPTH];
    logic [LINK_W-1:0]            link_next   [DEPTH];
    logic [LINK_W-1:0]            link_prev   [DEPTH];
    bit                           slot_used   [DEPTH];
    logic [LINK_W-1:0]            free_top;
    logic [LINK_W-1:0]            list_head;
    logic [LINK_W-1:0]            list_tail;
    logic [ilq_pkg::COUNT_W-1:0]  live_total;

    ilq_pkg::req_t pending_reqs [$];
    expected_rsp_t expected_rsps [$];
    expected_rsp_t oldest_rsp;

    int unsigned fail_count;
    int unsigned accepted_total;
    int unsigned drv_cycle;
    int unsigned mon_cycle;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          mode_left;
    bit          ready_next;
    bit          hold_rsp;

    int            random_issued;
    int            chunk_len;
    int            insert_pct;
    int            remove_pct;
    int            pick;
    ilq_pkg::req_t item;

    // Clock with a period of 8 time units.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one request to the shadow pool and returns the response it must produce.
    function automatic ilq_pkg::rsp_t apply_request(ilq_pkg::req_t r);
        ilq_pkg::rsp_t     o;
        logic [LINK_W-1:0] e;
        logic [LINK_W-1:0] n;
        logic [LINK_W-1:0] p;
        logic [ID_W-1:0]   id;
        bit                id_ok;
        bit                hit;
        o = '0;
        o.status = ilq_pkg::ST_BAD_ID;
        hit = 1'b0;
        e = NIL_LINK;
        id = r.entry_id[ID_W-1:0];
        id_ok = (r.entry_id < DEPTH) && slot_used[id];
        case (r.req_type)
            ilq_pkg::REQ_INSERT:
            begin
                e = free_top;
                if (e == NIL_LINK)
                    o.status = ilq_pkg::ST_FULL;
                else
                begin
                    free_top = link_next[e[ID_W-1:0]];
                    link_next[e[ID_W-1:0]] = NIL_LINK;
                    link_prev[e[ID_W-1:0]] = list_tail;
                    slot_handle[e[ID_W-1:0]] = r.payload_in;
                    slot_used[e[ID_W-1:0]] = 1'b1;
                    if (list_tail != NIL_LINK)
                        link_next[list_tail[ID_W-1:0]] = e;
                    else
                        list_head = e;
                    list_tail = e;
                    live_total++;
                    o.status = ilq_pkg::ST_OK;
                    o.assigned_id = ilq_pkg::ENTRY_ID_W'(e);
                end
            end
            ilq_pkg::REQ_REMOVE:
            begin
                if (id_ok)
                begin
                    e = LINK_W'(id);
                    n = link_next[id];
                    p = link_prev[id];
                    if (n != NIL_LINK)
                        link_prev[n[ID_W-1:0]] = p;
                    else
                        list_tail = p;
                    if (p != NIL_LINK)
                        link_next[p[ID_W-1:0]] = n;
                    else
                        list_head = n;
                    link_next[id] = free_top;
                    link_prev[id] = NIL_LINK;
                    slot_used[id] = 1'b0;
                    free_top = e;
                    live_total--;
                    o.status = ilq_pkg::ST_OK;
                end
            end
            ilq_pkg::REQ_READ:
            begin
                if (r.from_head)
                begin
                    e = list_head;
                    if (e == NIL_LINK)
                        o.status = ilq_pkg::ST_EMPTY;
                    else
                        hit = 1'b1;
                end
                else if (id_ok)
                begin
                    e = LINK_W'(id);
                    hit = 1'b1;
                end
                if (hit)
                begin
                    o.status = ilq_pkg::ST_OK;
                    o.payload_out = slot_handle[e[ID_W-1:0]];
                    if (link_next[e[ID_W-1:0]] != NIL_LINK)
                    begin
                        o.next_id = ilq_pkg::ENTRY_ID_W'(link_next[e[ID_W-1:0]]);
                        o.next_valid = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        o.used_count = live_total;
        return o;
    endfunction

    function automatic ilq_pkg::req_t make_req(logic [ilq_pkg::REQ_TYPE_W-1:0] kind, int id,
                                               bit head,
                                               logic [ilq_pkg::HANDLE_W-1:0] handle);
        ilq_pkg::req_t r;
        r.req_type   = kind;
        r.entry_id   = ilq_pkg::ENTRY_ID_W'(id);
        r.from_head  = head;
        r.payload_in = handle;
        return r;
    endfunction

    // Picks an id that is currently in the used list, or any in-range id if none is.
    function automatic int pick_live_id();
        int ids [$];
        for (int i = 0; i < DEPTH; i++)
            if (slot_used[i])
                ids.push_back(i);
        if (ids.size() == 0)
            return $urandom_range(0, DEPTH - 1);
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // Picks an id for a remove or read: mostly live entries, some any in range, a few from 0 to 255.
    function automatic int pick_target_id();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return pick_live_id();
        if (roll < 9)
            return $urandom_range(0, DEPTH - 1);
        return $urandom_range(0, 255);
    endfunction

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    // Request driver: offers pending transactions in bursts and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid   <= 1'b0;
            req_bus.payload <= '0;
            drv_cycle  = 0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            drv_cycle++;
            if (req_bus.valid && req_bus.ready)
            begin
                expected_rsps.push_back('{apply_request(pending_reqs.pop_front()), drv_cycle});
                accepted_total++;
            end
            // A transaction on offer stays in place until it is taken.
            if (!(req_bus.valid && !req_bus.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_bus.valid   <= 1'b1;
                    req_bus.payload <= pending_reqs[0];
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // Response monitor: checks each response against the oldest prediction and
    // stalls on a randomly chosen pattern that is redrawn whenever its run ends.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            mon_cycle  = 0;
            stall_mode = 0;
            mode_left  = 0;
        end
        else
        begin
            mon_cycle++;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                // A prediction made at this same edge cannot belong to this response.
                if (expected_rsps.size() == 0 || expected_rsps[0].accept_cycle >= mon_cycle)
                begin
                    $error("response transaction with no request waiting");
                    fail_count++;
                end
                else
                begin
                    oldest_rsp = expected_rsps.pop_front();
                    check_field("status", 64'(oldest_rsp.result.status),
                                64'(rsp_bus.payload.status));
                    check_field("assigned_id", 64'(oldest_rsp.result.assigned_id),
                                64'(rsp_bus.payload.assigned_id));
                    check_field("payload_out", 64'(oldest_rsp.result.payload_out),
                                64'(rsp_bus.payload.payload_out));
                    check_field("next_id", 64'(oldest_rsp.result.next_id),
                                64'(rsp_bus.payload.next_id));
                    check_field("next_valid", 64'(oldest_rsp.result.next_valid),
                                64'(rsp_bus.payload.next_valid));
                    check_field("used_count", 64'(oldest_rsp.result.used_count),
                                64'(rsp_bus.payload.used_count));
                end
            end
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            else
                mode_left--;
            case (stall_mode)
                0: ready_next = 1'b1;
                1: ready_next = 1'($urandom_range(0, 1));
                2: ready_next = ($urandom_range(0, 3) == 0);
                default: ready_next = (mon_cycle % 3 != 0);
            endcase
            rsp_bus.ready <= ready_next && !hold_rsp;
        end
    end

    // Long receiver hold-offs, so the block fills up and stalls its input.
    initial
    begin
        while (accepted_total < 300)
            @(negedge clk);
        hold_rsp = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
        while (accepted_total < 700)
            @(negedge clk);
        hold_rsp = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
    end

    // Reset, stimulus and end of run.
    initial
    begin
        rst_n <= 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_handle[i] = '0;
            link_next[i] = LINK_W'(i + 1);
            link_prev[i] = NIL_LINK;
            slot_used[i] = 1'b0;
        end
        free_top   = '0;
        list_head  = NIL_LINK;
        list_tail  = NIL_LINK;
        live_total = '0;

        // Directed part: empty list, bad ids, unknown request, fill to full, unlink
        // the middle, head and tail, then read from the head and by id and reuse a freed entry.
        pending_reqs.push_back(make_req(ilq_pkg::REQ_READ, 0, 1'b1, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_REMOVE, 0, 1'b0, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_READ, 255, 1'b0, '0));
        pending_reqs.push_back(make_req(REQ_UNKNOWN, 3, 1'b1, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_INSERT, 255, 1'b1, 32'h0000_0000));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_INSERT, 0, 1'b0, 32'hFFFF_FFFF));
        for (int i = 2; i < DEPTH; i++)
            pending_reqs.push_back(make_req(ilq_pkg::REQ_INSERT, i, 1'b0, $urandom));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_INSERT, 0, 1'b0, $urandom));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_REMOVE, 5, 1'b1, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_REMOVE, 0, 1'b0, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_REMOVE, DEPTH - 1, 1'b0, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_READ, 255, 1'b1, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_READ, DEPTH - 2, 1'b0, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_READ, DEPTH, 1'b0, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_REMOVE, DEPTH, 1'b0, '0));
        pending_reqs.push_back(make_req(ilq_pkg::REQ_INSERT, 0, 1'b0, $urandom));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Random part, built in chunks from the current pool so that most removes
        // and reads hit live entries; each chunk leans toward filling or draining.
        random_issued = 0;
        while (random_issued < RANDOM_ITEMS)
        begin
            while (pending_reqs.size() != 0)
                @(negedge clk);
            chunk_len = $urandom_range(4, 24);
            case ($urandom_range(0, 2))
                0:
                begin
                    insert_pct = 65;
                    remove_pct = 15;
                end
                1:
                begin
                    insert_pct = 15;
                    remove_pct = 60;
                end
                default:
                begin
                    insert_pct = 35;
                    remove_pct = 30;
                end
            endcase
            for (int k = 0; k < chunk_len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    item = make_req(REQ_UNKNOWN, $urandom_range(0, 255),
                                    1'($urandom_range(0, 1)), $urandom);
                else if (pick < insert_pct)
                    item = make_req(ilq_pkg::REQ_INSERT, $urandom_range(0, 255),
                                    1'($urandom_range(0, 1)), $urandom);
                else if (pick < insert_pct + remove_pct)
                    item = make_req(ilq_pkg::REQ_REMOVE, pick_target_id(),
                                    1'($urandom_range(0, 1)), $urandom);
                else
                    item = make_req(ilq_pkg::REQ_READ, pick_target_id(),
                                    ($urandom_range(0, 9) < 3), $urandom);
                pending_reqs.push_back(item);
                random_issued++;
            end
        end

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/ilq_pkg.sv
hdl/ilq_if.sv
hdl/ilq_ram.sv
hdl/indexed_linked_queue_with_free_list.sv
tb/indexed_linked_queue_with_free_list_test.sv
